// ===== hw/rtl/rtip_pkg.sv =====
// Shared types, constants and decode functions for the radix integer text parser.
package rtip_pkg;

  localparam int ACC_WIDTH_DEF    = 64;
  localparam int OFFSET_WIDTH_DEF = 8;
  localparam int BASE_W           = 6;
  localparam int CHAR_W           = 8;
  localparam int DIGIT_W          = 5;
  localparam int PHASE_W          = 3;
  localparam int CFG_INDEX_W      = 8;
  localparam int CFG_DATA_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = CFG_INDEX_W'(1);

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;

  localparam logic [BASE_W-1:0] BASE_OCT = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = DIGIT_W'(16);

  localparam logic [PHASE_W-1:0] PH_START       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_AFTER_SIGN  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_AUTO_ZERO   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_AUTO_ZERO_X = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HEX_ZERO    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DIGITS      = 3'd5;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BASE_W-1:0]  base;
    logic               neg;
    logic               stopped;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{phase: PH_START, base: '0, neg: 1'b0, stopped: 1'b0};

  // digit value 0..15, DIGIT_NONE for anything else
  function automatic logic [DIGIT_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] v;
    v = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      v = DIGIT_W'(c - CH_LOW_A) + DIGIT_W'(10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = DIGIT_W'(c - CH_UP_A) + DIGIT_W'(10);
    end
    return v;
  endfunction

  function automatic logic is_x(input logic [CHAR_W-1:0] c);
    return (c == CH_LOW_X) || (c == CH_UP_X);
  endfunction

endpackage

// ===== hw/rtl/radix_integer_text_parser.sv =====
// Top level: character input register, parser state, result register and config.
// m_axis_tvalid is registered; it rises once the last character leaves the input register.
// Throughput: one character per cycle while no last character waits on a held result;
// one 64 x 6 multiply-add per character sets the critical path.
// Backpressure on the result stalls intake only when a last character waits.
// Reset (rst, synchronous) clears config registers, parser state and valids.
module radix_integer_text_parser #(
  parameter int ACC_WIDTH    = rtip_pkg::ACC_WIDTH_DEF,
  parameter int OFFSET_WIDTH = rtip_pkg::OFFSET_WIDTH_DEF,
  parameter int OUT_W        = ((ACC_WIDTH + OFFSET_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtip_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rtip_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rtip_pkg::CHAR_W-1:0]        s_axis_tdata,   // char_code
  input  logic                               s_axis_tlast,   // last_char
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata    // parsed_value, stop_offset
);
  import rtip_pkg::*;

  logic [BASE_W-1:0]        number_base;
  logic                     signed_mode;

  logic                     s1_valid;
  logic [CHAR_W-1:0]        s1_char;
  logic                     s1_last;
  logic                     s1_adv;
  logic                     res_free;

  ctrl_t                    ctrl, ctrl_next;
  logic [ACC_WIDTH-1:0]     acc, acc_next;
  logic [OFFSET_WIDTH-1:0]  pos, pos_next;
  logic [OFFSET_WIDTH-1:0]  stop_pos, stop_pos_next;

  logic [ACC_WIDTH-1:0]     res_value;
  logic                     res_neg;
  logic [OFFSET_WIDTH-1:0]  res_stop;
  logic [ACC_WIDTH-1:0]     out_value;

  assign cfg_ready     = 1'b1;
  assign res_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && (!s1_last || res_free);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= '0;
      signed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_NUMBER_BASE) begin
        number_base <= cfg_data[BASE_W-1:0];
      end else if (cfg_index == CFG_SIGNED_MODE) begin
        signed_mode <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_char <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  rtip_step #(
    .ACC_WIDTH    (ACC_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_step (
    .ctrl          (ctrl),
    .acc           (acc),
    .pos           (pos),
    .stop_pos      (stop_pos),
    .char_code     (s1_char),
    .last_char     (s1_last),
    .cfg_base      (number_base),
    .cfg_signed    (signed_mode),
    .ctrl_next     (ctrl_next),
    .acc_next      (acc_next),
    .pos_next      (pos_next),
    .stop_pos_next (stop_pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_last)) begin
      ctrl     <= CTRL_RESET;
      acc      <= '0;
      pos      <= '0;
      stop_pos <= '0;
    end else if (s1_adv) begin
      ctrl     <= ctrl_next;
      acc      <= acc_next;
      pos      <= pos_next;
      stop_pos <= stop_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      res_value <= acc_next;
      res_neg   <= ctrl_next.neg;
      res_stop  <= stop_pos_next;
    end
  end

  assign out_value    = res_neg ? (ACC_WIDTH'(0) - res_value) : res_value;
  assign m_axis_tdata = OUT_W'({res_stop, out_value});

endmodule

// ===== hw/rtl/rtip_step.sv =====
// Per-character next-state logic: prefix handling, digit accumulate, stop tracking.
module rtip_step #(
  parameter int ACC_WIDTH    = rtip_pkg::ACC_WIDTH_DEF,
  parameter int OFFSET_WIDTH = rtip_pkg::OFFSET_WIDTH_DEF
) (
  input  rtip_pkg::ctrl_t                  ctrl,
  input  logic [ACC_WIDTH-1:0]             acc,
  input  logic [OFFSET_WIDTH-1:0]          pos,
  input  logic [OFFSET_WIDTH-1:0]          stop_pos,
  input  logic [rtip_pkg::CHAR_W-1:0]      char_code,
  input  logic                             last_char,
  input  logic [rtip_pkg::BASE_W-1:0]      cfg_base,
  input  logic                             cfg_signed,
  output rtip_pkg::ctrl_t                  ctrl_next,
  output logic [ACC_WIDTH-1:0]             acc_next,
  output logic [OFFSET_WIDTH-1:0]          pos_next,
  output logic [OFFSET_WIDTH-1:0]          stop_pos_next
);
  import rtip_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

  logic [DIGIT_W-1:0]             digit;
  logic [BASE_W-1:0]              begin_base;
  logic [BASE_W-1:0]              mul_base;
  logic                           do_take;
  logic [ACC_WIDTH+BASE_W-1:0]    product;

  assign digit      = hex_val(char_code);
  assign begin_base = (ctrl.phase == PH_START) ? cfg_base : ctrl.base;
  // radix in effect for a digit taken this cycle
  assign mul_base   = (ctrl.phase == PH_START || ctrl.phase == PH_AFTER_SIGN) ?
                        ((begin_base == '0) ? BASE_DEC : begin_base) :
                      (ctrl.phase == PH_AUTO_ZERO_X) ? BASE_HEX : ctrl.base;
  assign product    = acc * mul_base;
  assign pos_next   = (pos == POS_MAX) ? POS_MAX : pos + OFFSET_WIDTH'(1);

  always_comb begin
    ctrl_next     = ctrl;
    acc_next      = acc;
    stop_pos_next = stop_pos;
    do_take       = 1'b0;
    if (!ctrl.stopped) begin
      case (ctrl.phase)
        PH_START, PH_AFTER_SIGN: begin
          ctrl_next.base = begin_base;
          if (ctrl.phase == PH_START && cfg_signed && char_code == CH_MINUS) begin
            ctrl_next.neg   = 1'b1;
            ctrl_next.phase = PH_AFTER_SIGN;
          end else if (begin_base == '0) begin
            if (char_code == CH_ZERO) begin
              ctrl_next.base  = BASE_OCT;
              ctrl_next.phase = PH_AUTO_ZERO;
            end else begin
              ctrl_next.base = BASE_DEC;
              do_take        = 1'b1;
            end
          end else if (begin_base == BASE_HEX && char_code == CH_ZERO) begin
            ctrl_next.phase = PH_HEX_ZERO;
          end else begin
            do_take = 1'b1;
          end
        end
        PH_AUTO_ZERO: begin
          if (is_x(char_code)) begin
            stop_pos_next   = pos;
            ctrl_next.phase = PH_AUTO_ZERO_X;
          end else begin
            do_take = 1'b1;
          end
        end
        PH_AUTO_ZERO_X: begin
          if (digit != DIGIT_NONE) begin
            ctrl_next.base = BASE_HEX;
            do_take        = 1'b1;
          end else begin
            ctrl_next.stopped = 1'b1;  // stop stays at the 'x'
          end
        end
        PH_HEX_ZERO: begin
          if (is_x(char_code)) begin
            ctrl_next.phase = PH_DIGITS;
          end else begin
            do_take = 1'b1;
          end
        end
        default: begin
          do_take = 1'b1;
        end
      endcase

      if (do_take) begin
        ctrl_next.phase = PH_DIGITS;
        if (digit != DIGIT_NONE && {1'b0, digit} < mul_base) begin
          acc_next = product[ACC_WIDTH-1:0] + ACC_WIDTH'(digit);
        end else begin
          ctrl_next.stopped = 1'b1;
          stop_pos_next     = pos;
        end
      end
    end

    // end of string acts as terminator
    if (last_char && !ctrl_next.stopped) begin
      if (ctrl_next.phase != PH_AUTO_ZERO_X) begin
        stop_pos_next = pos_next;
      end
      ctrl_next.stopped = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/rtip_checker.sv =====
// Port-level checks for the radix integer text parser, bound to the top level.
module rtip_checker #(
  parameter int OUT_W = 72
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind radix_integer_text_parser rtip_checker #(.OUT_W(OUT_W)) u_rtip_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for radix_integer_text_parser: directed and random strings vs. predictor.
`timescale 1ns / 100ps

module testbench;
  import rtip_pkg::*;

  localparam logic [6:0] NOT_DIGIT = 7'd99;
  localparam logic [7:0] MAX_OFFSET = 8'hff;
  localparam int PHASE_TARGET = 115;
  localparam logic [5:0] RAND_BASES [10] = '{6'd0, 6'd0, 6'd16, 6'd10, 6'd8,
                                             6'd2, 6'd1, 6'd36, 6'd17, 6'd16};
  localparam bit RAND_SIGNS [10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                     1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  offset;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // char_code
  logic        s_axis_tlast = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // parsed_value, stop_offset

  radix_integer_text_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [5:0]         cfg_base = '0;
  bit                 cfg_signed = 1'b0;
  logic [63:0]        acc_value = '0;
  logic [5:0]         run_base = '0;
  logic [PHASE_W-1:0] run_phase = PH_START;
  logic [7:0]         char_pos = '0;
  logic [7:0]         stop_pos = '0;
  bit                 run_negative = 1'b0;
  bit                 run_stopped = 1'b0;

  parse_result_t pending_results[$];
  int mismatches = 0;
  int burst_left = 0;

  function automatic logic [6:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 7'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return 7'(c - CH_LOW_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_F) return 7'(c - CH_UP_A + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic void accum_digit(input logic [7:0] c, input logic [7:0] pos);
    logic [6:0] v;
    v = digit_value(c);
    run_phase = PH_DIGITS;
    if (v < run_base) begin
      acc_value = acc_value * run_base + v;
    end else begin
      run_stopped = 1'b1;
      stop_pos = pos;
    end
  endfunction

  function automatic void start_digits(input logic [7:0] c, input logic [7:0] pos);
    if (run_base == 0) begin
      if (c == CH_ZERO) begin
        run_base = BASE_OCT;
        run_phase = PH_AUTO_ZERO;
      end else begin
        run_base = BASE_DEC;
        accum_digit(c, pos);
      end
    end else if (run_base == BASE_HEX && c == CH_ZERO) begin
      run_phase = PH_HEX_ZERO;
    end else begin
      accum_digit(c, pos);
    end
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input bit last,
                                    output parse_result_t r);
    logic [7:0] pos;
    logic [7:0] nxt;
    bit is_x_char;
    pos = char_pos;
    nxt = (pos < MAX_OFFSET) ? pos + 8'd1 : MAX_OFFSET;
    is_x_char = (c == CH_LOW_X) || (c == CH_UP_X);
    r = '0;
    if (!run_stopped) begin
      case (run_phase)
        PH_START: begin
          run_base = cfg_base;
          if (cfg_signed && c == CH_MINUS) begin
            run_negative = 1'b1;
            run_phase = PH_AFTER_SIGN;
          end else begin
            start_digits(c, pos);
          end
        end
        PH_AFTER_SIGN: start_digits(c, pos);
        PH_AUTO_ZERO: begin
          if (is_x_char) begin
            stop_pos = pos;
            run_phase = PH_AUTO_ZERO_X;
          end else begin
            accum_digit(c, pos);
          end
        end
        PH_AUTO_ZERO_X: begin
          if (digit_value(c) < 7'd16) begin
            run_base = BASE_HEX;
            accum_digit(c, pos);
          end else begin
            run_stopped = 1'b1;
          end
        end
        PH_HEX_ZERO: begin
          if (is_x_char) run_phase = PH_DIGITS;
          else accum_digit(c, pos);
        end
        default: accum_digit(c, pos);
      endcase
    end
    char_pos = nxt;
    if (!last) return 1'b0;
    if (!run_stopped && run_phase != PH_AUTO_ZERO_X) stop_pos = nxt;
    r.value = run_negative ? 64'd0 - acc_value : acc_value;
    r.offset = stop_pos;
    acc_value = '0;
    run_base = '0;
    run_phase = PH_START;
    char_pos = '0;
    stop_pos = '0;
    run_negative = 1'b0;
    run_stopped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    parse_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== exp_r.value)
          report_mismatch("parsed_value", m_axis_tdata[63:0], exp_r.value);
        if (m_axis_tdata[71:64] !== exp_r.offset)
          report_mismatch("stop_offset", m_axis_tdata[71:64], exp_r.offset);
      end
    end
  end

  // result-side stall pattern: free-running, random, or long runs of stall/accept
  logic [7:0] rx_cycle = '0;
  logic [1:0] rx_mode = '0;
  int rx_hold = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle == 8'd0) rx_mode <= 2'($urandom_range(0, 2));
    case (rx_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
        end else begin
          m_axis_tready <= ~m_axis_tready;
          rx_hold <= $urandom_range(0, 20);
        end
      end
    endcase
  end

  task automatic send_char(input logic [7:0] c, input bit last);
    parse_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (parse_char(c, last, r)) pending_results.push_back(r);
  endtask

  task automatic send_queue(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string t);
    logic [7:0] text[$];
    for (int i = 0; i < t.len(); i++) text.push_back(t[i]);
    send_queue(text);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] base, input bit sgn);
    drain();
    cfg_index <= CFG_NUMBER_BASE;
    cfg_data <= {2'b00, base};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_base = base;
    cfg_index <= CFG_SIGNED_MODE;
    cfg_data <= {7'd0, sgn};
    do @(posedge clk); while (!cfg_ready);
    cfg_signed = sgn;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] x_char();
    return $urandom_range(0, 1) ? CH_LOW_X : CH_UP_X;
  endfunction

  // mostly well-formed numbers for the current base, some noise and broken strings
  task automatic build_text(ref logic [7:0] s[$], input bit long_text);
    int roll;
    int lim;
    int n;
    roll = $urandom_range(0, 99);
    s.delete();
    if (roll < 10 && !long_text) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) s.push_back(CH_MINUS);
    lim = (cfg_base > 16) ? 16 : int'(cfg_base);
    if (cfg_base == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          s.push_back(CH_ZERO);
          s.push_back(x_char());
          lim = 16;
        end
        1: begin
          s.push_back(CH_ZERO);
          lim = 8;
        end
        default: begin
          s.push_back(digit_char($urandom_range(1, 9)));
          lim = 10;
        end
      endcase
    end else if (cfg_base == BASE_HEX && $urandom_range(0, 1)) begin
      s.push_back(CH_ZERO);
      s.push_back(x_char());
    end
    if (long_text) n = $urandom_range(256, 280);
    else if (roll < 30) n = $urandom_range(12, 28);
    else n = $urandom_range(0, 8);
    repeat (n) s.push_back(digit_char($urandom_range(0, lim - 1)));
    if (roll >= 85) begin
      n = $urandom_range(1, 3);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else if (roll >= 78 && s.size() > 0) begin
      s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if (s.size() == 0) s.push_back(digit_char(0));
  endtask

  task automatic test_auto_detect();
    set_config(6'd0, 1'b0);
    send_text("0x1F");
    send_text("09");
    send_text("0x");
    send_text("-");
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_signed_minus();
    set_config(6'd0, 1'b1);
    send_text("-");
    send_text("-0x1");
  endtask

  task automatic test_fixed_bases();
    set_config(BASE_HEX, 1'b0);
    send_text("0x");
    set_config(6'd1, 1'b0);
    send_text("01");
    set_config(6'd36, 1'b1);
    send_text("Fz");
  endtask

  task automatic test_random_strings();
    logic [7:0] text[$];
    logic [5:0] base;
    bit sgn;
    int sent;
    for (int p = 0; p < 12; p++) begin
      if (p < 10) begin
        base = RAND_BASES[p];
        sgn = RAND_SIGNS[p];
      end else begin
        base = 6'($urandom_range(0, 36));
        sgn = 1'($urandom_range(0, 1));
      end
      set_config(base, sgn);
      sent = 0;
      while (sent < PHASE_TARGET) begin
        build_text(text, p == 3 && sent == 0);
        send_queue(text);
        sent += text.size();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_auto_detect();
    test_signed_minus();
    test_fixed_bases();
    test_random_strings();
    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rtip_pkg.sv
hw/rtl/rtip_step.sv
hw/rtl/radix_integer_text_parser.sv
hw/rtl/rtip_checker.sv
tb/sv/testbench.sv
